// ----- rtl/core/fridge_thermostat_controller_macros.svh -----
// Assertion macros for the fridge thermostat controller.
// Expects clk_i and rst_ni in the scope of use.
`ifndef FRIDGE_THERMOSTAT_CONTROLLER_MACROS_SVH
`define FRIDGE_THERMOSTAT_CONTROLLER_MACROS_SVH

// Same-cycle implication.
`define FTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ftc_pkg.sv -----
// Types and constants for the fridge thermostat controller.
// No dependencies.
package ftc_pkg;

  localparam int unsigned TempW = 12;
  localparam int unsigned CmpW  = 15;  // doubled band edges and margins

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_CMD    = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    CMD_TOGGLE_COMP  = 3'd0,
    CMD_TOGGLE_FAN   = 3'd1,
    CMD_TOGGLE_LIGHT = 3'd2,
    CMD_KILL_ON      = 3'd3,
    CMD_KILL_OFF     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_OVERHEAT = 2'd1,
    CAUSE_ONTIME   = 2'd2
  } cause_e;

  typedef enum logic [2:0] {
    CFG_TARGET_TEMP    = 3'd0,
    CFG_TEMP_BAND      = 3'd1,
    CFG_FAN_MARGIN     = 3'd2,
    CFG_OVERHEAT_LIMIT = 3'd3,
    CFG_MAX_ON_MINUTES = 3'd4,
    CFG_FAN_PERIOD_S   = 3'd5,
    CFG_FAN_PULSE_S    = 3'd6,
    CFG_FAN_RUNON_S    = 3'd7
  } cfg_idx_e;

  localparam logic [5:0] SecPerMin = 6'd60;
  localparam logic [6:0] MinSat    = 7'd127;

  typedef struct packed {
    logic        [1:0]       func;
    logic signed [TempW-1:0] cabinet_temp;
    logic                    cabinet_valid;
    logic signed [TempW-1:0] compressor_temp;
    logic        [2:0]       command;
  } ftc_in_t;

  typedef struct packed {
    logic       compressor_relay;
    logic       fan_relay;
    logic       light_relay;
    logic       kill_active;
    logic       cooling_active;
    logic [1:0] kill_cause;
  } ftc_out_t;

  typedef struct packed {
    logic signed [TempW-1:0] target_temp;
    logic        [9:0]       temp_band;
    logic        [7:0]       fan_margin;
    logic signed [TempW-1:0] overheat_limit;
    logic        [6:0]       max_on_minutes;
    logic        [11:0]      fan_period_s;
    logic        [7:0]       fan_pulse_s;
    logic        [7:0]       fan_runon_s;
  } ftc_cfg_t;

  localparam ftc_cfg_t CfgReset = '{
    target_temp:    12'sd120,
    temp_band:      10'd48,
    fan_margin:     8'd6,
    overheat_limit: 12'sd800,
    max_on_minutes: 7'd60,
    fan_period_s:   12'd300,
    fan_pulse_s:    8'd20,
    fan_runon_s:    8'd60
  };

  typedef struct packed {
    logic        compressor_on;
    logic        fan_on;
    logic        light_on;
    logic        killed;
    logic        cooling;
    logic [11:0] period_count;
    logic [7:0]  pulse_left;
    logic [7:0]  runon_left;
    logic [5:0]  on_seconds;
    logic [6:0]  on_minutes;
  } ftc_state_t;

endpackage

// ----- rtl/core/ftc_step.sv -----
// Next-state and result logic for one item of the thermostat controller.
// Depends on ftc_pkg.
module ftc_step import ftc_pkg::*; (
  input  ftc_cfg_t   cfg_i,
  input  ftc_state_t st_i,
  input  ftc_in_t    item_i,
  output ftc_state_t st_o,
  output ftc_out_t   res_o
);

  logic signed [CmpW-1:0] t2, tgt2, band, margin2, low2, high2, fan2;
  logic [7:0] pulse_len, runon_len;

  assign pulse_len = (cfg_i.fan_pulse_s == 8'd0) ? 8'd1 : cfg_i.fan_pulse_s;
  assign runon_len = (cfg_i.fan_runon_s == 8'd0) ? 8'd1 : cfg_i.fan_runon_s;

  // Half-band edges compared at twice the scale to stay exact.
  assign t2      = {{2{item_i.cabinet_temp[TempW-1]}}, item_i.cabinet_temp, 1'b0};
  assign tgt2    = {{2{cfg_i.target_temp[TempW-1]}}, cfg_i.target_temp, 1'b0};
  assign band    = {5'd0, cfg_i.temp_band};
  assign margin2 = {6'd0, cfg_i.fan_margin, 1'b0};
  assign low2    = tgt2 - band;
  assign high2   = tgt2 + band;
  assign fan2    = high2 - margin2;

  always_comb begin
    ftc_state_t s;
    logic [1:0] cause;
    s     = st_i;
    cause = CAUSE_NONE;
    case (item_i.func)
      FUNC_TICK: begin
        if (s.compressor_on) begin
          s.on_seconds = s.on_seconds + 6'd1;
          if (s.on_seconds >= SecPerMin) begin
            s.on_seconds = 6'd0;
            if (s.on_minutes < MinSat) s.on_minutes = s.on_minutes + 7'd1;
          end
          if (s.on_minutes > cfg_i.max_on_minutes) begin
            // compressor was on, so the on-time counters clear
            s.compressor_on = 1'b0;
            s.on_seconds    = 6'd0;
            s.on_minutes    = 7'd0;
            s.fan_on        = 1'b0;
            s.light_on      = 1'b0;
            s.killed        = 1'b1;
            cause           = CAUSE_ONTIME;
          end
        end
        if (s.runon_left != 8'd0) begin
          s.runon_left = s.runon_left - 8'd1;
          if (s.runon_left == 8'd0 && !s.cooling) s.fan_on = 1'b0;
        end
        if (s.pulse_left != 8'd0) begin
          s.pulse_left = s.pulse_left - 8'd1;
          if (s.pulse_left == 8'd0 && !s.cooling) s.fan_on = 1'b0;
        end
        s.period_count = s.period_count + 12'd1;
        if (s.period_count >= cfg_i.fan_period_s) begin
          s.period_count = 12'd0;
          if (!s.killed && !s.cooling) begin
            s.fan_on     = 1'b1;
            s.pulse_left = pulse_len;
          end
        end
      end
      FUNC_SAMPLE: begin
        if (item_i.compressor_temp > cfg_i.overheat_limit) begin
          if (s.compressor_on) begin
            s.on_seconds = 6'd0;
            s.on_minutes = 7'd0;
          end
          s.compressor_on = 1'b0;
          s.fan_on        = 1'b0;
          s.light_on      = 1'b0;
          s.killed        = 1'b1;
          cause           = CAUSE_OVERHEAT;
        end
        if (!s.killed) begin
          if (!item_i.cabinet_valid) begin
            if (s.compressor_on) begin
              s.on_seconds = 6'd0;
              s.on_minutes = 7'd0;
            end
            s.compressor_on = 1'b0;
            s.fan_on        = 1'b0;
            s.cooling       = 1'b0;
          end else begin
            if (t2 < low2) begin
              if (s.compressor_on) begin
                s.on_seconds = 6'd0;
                s.on_minutes = 7'd0;
              end
              s.compressor_on = 1'b0;
              s.runon_left    = runon_len;
              s.cooling       = 1'b0;
            end else if (t2 > high2) begin
              if (!s.compressor_on) begin
                s.on_seconds = 6'd0;
                s.on_minutes = 7'd0;
              end
              s.compressor_on = 1'b1;
              s.cooling       = 1'b1;
              s.fan_on        = 1'b1;
            end
            if (t2 > fan2) begin
              s.fan_on  = 1'b1;
              s.cooling = 1'b1;
            end
          end
        end
      end
      FUNC_CMD: begin
        case (item_i.command)
          CMD_TOGGLE_COMP: begin
            s.compressor_on = ~s.compressor_on;
            s.on_seconds    = 6'd0;
            s.on_minutes    = 7'd0;
          end
          CMD_TOGGLE_FAN:   s.fan_on   = ~s.fan_on;
          CMD_TOGGLE_LIGHT: s.light_on = ~s.light_on;
          CMD_KILL_ON: begin
            if (s.compressor_on) begin
              s.on_seconds = 6'd0;
              s.on_minutes = 7'd0;
            end
            s.compressor_on = 1'b0;
            s.fan_on        = 1'b0;
            s.light_on      = 1'b0;
            s.killed        = 1'b1;
          end
          CMD_KILL_OFF: s.killed = 1'b0;
          default: ;
        endcase
      end
      default: ;
    endcase
    st_o                   = s;
    res_o.compressor_relay = s.compressor_on;
    res_o.fan_relay        = s.fan_on;
    res_o.light_relay      = s.light_on;
    res_o.kill_active      = s.killed;
    res_o.cooling_active   = s.cooling;
    res_o.kill_cause       = cause;
  end

endmodule

// ----- rtl/core/fridge_thermostat_controller.sv -----
// Fridge thermostat controller: an accepted input is held in the input register, then
// the state update writes the result register, which raises result valid. Throughput
// one item per cycle while the receiver does not stall the output; the single
// state update between the two registers sets that figure.
// Reset: the relay, kill, cooling and timer state clears; configuration registers take
// their default values. Depends on ftc_pkg, ftc_step and the macros header.
`include "fridge_thermostat_controller_macros.svh"

module fridge_thermostat_controller import ftc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ftc_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ftc_out_t    out_data_o
);

  ftc_cfg_t   cfg_q;
  ftc_state_t st_q, st_d;
  ftc_in_t    in_q;
  logic       in_v_q;
  ftc_out_t   out_q, res;
  logic       out_v_q;
  logic       adv;

  assign adv        = in_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET_TEMP:    cfg_q.target_temp    <= cfg_wdata_i;
        CFG_TEMP_BAND:      cfg_q.temp_band      <= cfg_wdata_i[9:0];
        CFG_FAN_MARGIN:     cfg_q.fan_margin     <= cfg_wdata_i[7:0];
        CFG_OVERHEAT_LIMIT: cfg_q.overheat_limit <= cfg_wdata_i;
        CFG_MAX_ON_MINUTES: cfg_q.max_on_minutes <= cfg_wdata_i[6:0];
        CFG_FAN_PERIOD_S:   cfg_q.fan_period_s   <= cfg_wdata_i;
        CFG_FAN_PULSE_S:    cfg_q.fan_pulse_s    <= cfg_wdata_i[7:0];
        CFG_FAN_RUNON_S:    cfg_q.fan_runon_s    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  ftc_step u_step (
    .cfg_i  (cfg_q),
    .st_i   (st_q),
    .item_i (in_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      st_q    <= '0;
    end else begin
      if (in_ready_o) in_v_q <= in_valid_i;
      if (adv) begin
        out_v_q <= 1'b1;
        st_q    <= st_d;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (adv) out_q <= res;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `FTC_ASSERT_IMP(a_cause_kills, out_v_q && out_q.kill_cause != CAUSE_NONE,
                  out_q.kill_active && !out_q.compressor_relay && !out_q.fan_relay &&
                  !out_q.light_relay, "kill cause without kill state")
  `FTC_ASSERT_NXT(a_state_holds, !adv, $stable(st_q), "state changed without an item")
  `FTC_ASSERT_IMP(a_sec_range, 1'b1, st_q.on_seconds < SecPerMin, "on_seconds out of range")
  `FTC_ASSERT_IMP(a_no_overrun, out_v_q && !out_ready_i, !adv, "result overwritten while stalled")

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for fridge_thermostat_controller: drives ticks, samples
// and commands, predicts each relay beat in SV and compares it field by field.
// Depends on ftc_pkg and the controller RTL.
module tb_top;
  import ftc_pkg::*;

  localparam int StallLimit = 2000;
  localparam logic [1:0] FuncUnknown = 2'd3;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = 3'd0;
  logic [11:0] cfg_wdata_i = 12'd0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  ftc_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  ftc_out_t    out_data_o;

  fridge_thermostat_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  ftc_in_t    items_to_send[$];
  ftc_out_t   relays_due[$];
  ftc_state_t fridge   = '0;
  ftc_cfg_t   settings = CfgReset;
  int         errors = 0;
  int         queued = 0;
  int         sender_idle_pct = 0;
  int         rx_idle_pct = 0;
  logic       rx_hold_req = 1'b0;
  logic       rx_hold_taken = 1'b0;
  int         rx_hold_left = 0;
  int         stall_cycles = 0;

  // ---------------- thermostat prediction ----------------
  function automatic void set_compressor(logic on);
    if (fridge.compressor_on != on) begin
      fridge.compressor_on = on;
      fridge.on_seconds    = '0;
      fridge.on_minutes    = '0;
    end
  endfunction

  function automatic void engage_kill();
    set_compressor(1'b0);
    fridge.fan_on   = 1'b0;
    fridge.light_on = 1'b0;
    fridge.killed   = 1'b1;
  endfunction

  function automatic logic [7:0] at_least_one(logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic ftc_out_t next_relays(ftc_in_t it);
    ftc_out_t r;
    cause_e   cause;
    int       cab2, low2, high2;
    cause = CAUSE_NONE;
    case (it.func)
      FUNC_TICK: begin
        if (fridge.compressor_on) begin
          fridge.on_seconds = fridge.on_seconds + 6'd1;
          if (fridge.on_seconds >= SecPerMin) begin
            fridge.on_seconds = '0;
            if (fridge.on_minutes != MinSat) fridge.on_minutes = fridge.on_minutes + 7'd1;
          end
          if (fridge.on_minutes > settings.max_on_minutes) begin
            engage_kill();
            cause = CAUSE_ONTIME;
          end
        end
        if (fridge.runon_left != 0) begin
          fridge.runon_left = fridge.runon_left - 8'd1;
          if (fridge.runon_left == 0 && !fridge.cooling) fridge.fan_on = 1'b0;
        end
        if (fridge.pulse_left != 0) begin
          fridge.pulse_left = fridge.pulse_left - 8'd1;
          if (fridge.pulse_left == 0 && !fridge.cooling) fridge.fan_on = 1'b0;
        end
        fridge.period_count = fridge.period_count + 12'd1;
        if (fridge.period_count >= settings.fan_period_s) begin
          fridge.period_count = '0;
          if (!fridge.killed && !fridge.cooling) begin
            fridge.fan_on     = 1'b1;
            fridge.pulse_left = at_least_one(settings.fan_pulse_s);
          end
        end
      end
      FUNC_SAMPLE: begin
        if (int'($signed(it.compressor_temp)) > int'($signed(settings.overheat_limit))) begin
          engage_kill();
          cause = CAUSE_OVERHEAT;
        end
        if (!fridge.killed) begin
          if (!it.cabinet_valid) begin
            set_compressor(1'b0);
            fridge.fan_on  = 1'b0;
            fridge.cooling = 1'b0;
          end else begin
            // band edges doubled so an odd band width stays exact
            cab2  = 2 * int'($signed(it.cabinet_temp));
            low2  = 2 * int'($signed(settings.target_temp)) - int'(settings.temp_band);
            high2 = 2 * int'($signed(settings.target_temp)) + int'(settings.temp_band);
            if (cab2 < low2) begin
              set_compressor(1'b0);
              fridge.runon_left = at_least_one(settings.fan_runon_s);
              fridge.cooling    = 1'b0;
            end else if (cab2 > high2) begin
              set_compressor(1'b1);
              fridge.cooling = 1'b1;
              fridge.fan_on  = 1'b1;
            end
            if (cab2 > high2 - 2 * int'(settings.fan_margin)) begin
              fridge.fan_on  = 1'b1;
              fridge.cooling = 1'b1;
            end
          end
        end
      end
      FUNC_CMD: begin
        case (it.command)
          CMD_TOGGLE_COMP:  set_compressor(!fridge.compressor_on);
          CMD_TOGGLE_FAN:   fridge.fan_on = !fridge.fan_on;
          CMD_TOGGLE_LIGHT: fridge.light_on = !fridge.light_on;
          CMD_KILL_ON:      engage_kill();
          CMD_KILL_OFF:     fridge.killed = 1'b0;
          default: ;
        endcase
      end
      default: ;
    endcase
    r.compressor_relay = fridge.compressor_on;
    r.fan_relay        = fridge.fan_on;
    r.light_relay      = fridge.light_on;
    r.kill_active      = fridge.killed;
    r.cooling_active   = fridge.cooling;
    r.kill_cause       = cause;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // ---------------- driver / receiver / monitor ----------------
  always @(posedge clk_i or negedge rst_ni) begin : driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (items_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= items_to_send.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : receiver
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_hold_req && !rx_hold_taken) begin
      // long back-pressure so the block fills and stalls its input
      rx_hold_taken <= 1'b1;
      rx_hold_left  <= 300;
      out_ready_i   <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready_i  <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    ftc_out_t want;
    if (!rst_ni) begin
      fridge   = '0;
      settings = CfgReset;
      relays_due.delete();
    end else begin
      // result beat first: it can never belong to the input beat of this edge
      if (out_valid_o && out_ready_i) begin
        if (relays_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, actual %p",
                   $time, out_data_o);
        end else begin
          want = relays_due.pop_front();
          check_field("compressor_relay", want.compressor_relay, out_data_o.compressor_relay);
          check_field("fan_relay", want.fan_relay, out_data_o.fan_relay);
          check_field("light_relay", want.light_relay, out_data_o.light_relay);
          check_field("kill_active", want.kill_active, out_data_o.kill_active);
          check_field("cooling_active", want.cooling_active, out_data_o.cooling_active);
          check_field("kill_cause", want.kill_cause, out_data_o.kill_cause);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TARGET_TEMP:    settings.target_temp    = cfg_wdata_i;
          CFG_TEMP_BAND:      settings.temp_band      = cfg_wdata_i[9:0];
          CFG_FAN_MARGIN:     settings.fan_margin     = cfg_wdata_i[7:0];
          CFG_OVERHEAT_LIMIT: settings.overheat_limit = cfg_wdata_i;
          CFG_MAX_ON_MINUTES: settings.max_on_minutes = cfg_wdata_i[6:0];
          CFG_FAN_PERIOD_S:   settings.fan_period_s   = cfg_wdata_i;
          CFG_FAN_PULSE_S:    settings.fan_pulse_s    = cfg_wdata_i[7:0];
          CFG_FAN_RUNON_S:    settings.fan_runon_s    = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) relays_due.push_back(next_relays(in_data_i));
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------- stimulus ----------------
  function automatic int clamp12(int v);
    return (v > 2047) ? 2047 : ((v < -2048) ? -2048 : v);
  endfunction

  function automatic ftc_in_t noise_item();
    logic [31:0] r;
    ftc_in_t     it;
    r  = $urandom;
    it = r[$bits(ftc_in_t)-1:0];
    return it;
  endfunction

  function automatic ftc_in_t tick_item();
    ftc_in_t it;
    it      = noise_item();
    it.func = FUNC_TICK;
    return it;
  endfunction

  function automatic ftc_in_t sample_item(int cab, logic ok, int comp);
    ftc_in_t it;
    it                 = noise_item();
    it.func            = FUNC_SAMPLE;
    it.cabinet_temp    = 12'(clamp12(cab));
    it.cabinet_valid   = ok;
    it.compressor_temp = 12'(clamp12(comp));
    return it;
  endfunction

  function automatic ftc_in_t cmd_item(logic [2:0] c);
    ftc_in_t it;
    it         = noise_item();
    it.func    = FUNC_CMD;
    it.command = c;
    return it;
  endfunction

  task automatic push_item(ftc_in_t it);
    items_to_send.push_back(it);
    queued++;
  endtask

  // compressor reading at or below the limit, now and then anything
  function automatic int cool_comp(int ovh);
    logic [11:0] r;
    r = 12'($urandom);
    if ($urandom_range(99) < 5) return int'($signed(r));
    return int'($urandom_range(ovh + 2048, 0)) - 2048;
  endfunction

  task automatic write_cfg(cfg_idx_e idx, logic [11:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_config(int target, int band, int margin, int ovh,
                            int max_on, int period, int pulse, int runon);
    write_cfg(CFG_TARGET_TEMP, 12'(target));
    write_cfg(CFG_TEMP_BAND, 12'(band));
    write_cfg(CFG_FAN_MARGIN, 12'(margin));
    write_cfg(CFG_OVERHEAT_LIMIT, 12'(ovh));
    write_cfg(CFG_MAX_ON_MINUTES, 12'(max_on));
    write_cfg(CFG_FAN_PERIOD_S, 12'(period));
    write_cfg(CFG_FAN_PULSE_S, 12'(pulse));
    write_cfg(CFG_FAN_RUNON_S, 12'(runon));
    @(negedge clk_i);
  endtask

  // stimulus waits until every queued item is sent and every predicted beat has come out
  task automatic wait_drained();
    do @(negedge clk_i);
    while (items_to_send.size() != 0 || in_valid_i || relays_due.size() != 0);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic queue_random(int count);
    int target, half, ovh, stop_at, pick, n, i;
    target  = int'($signed(settings.target_temp));
    half    = int'(settings.temp_band) / 2;
    ovh     = int'($signed(settings.overheat_limit));
    stop_at = queued + count;
    while (queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        // cooling cycle: hot read, ticks and in-band reads, cold read, run-on ticks
        if ($urandom_range(99) < 60) push_item(cmd_item(CMD_KILL_OFF));
        push_item(sample_item(target + half + 1 + $urandom_range(15),
                              $urandom_range(99) >= 5, cool_comp(ovh)));
        n = ($urandom_range(99) < 20) ? $urandom_range(140, 60) : $urandom_range(40, 1);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(99) < 10)
            push_item(sample_item(target - half + $urandom_range(2 * half), 1'b1,
                                  cool_comp(ovh)));
          else
            push_item(tick_item());
        end
        push_item(sample_item(target - half - 1 - $urandom_range(15),
                              $urandom_range(99) >= 5, cool_comp(ovh)));
        n = $urandom_range(40);
        for (i = 0; i < n; i++) push_item(tick_item());
      end else if (pick < 80) begin
        n = $urandom_range(4, 1);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(99) < 30) push_item(cmd_item(CMD_KILL_OFF));
          else push_item(cmd_item(3'($urandom_range(7))));
        end
      end else begin
        n = $urandom_range(5, 1);
        for (i = 0; i < n; i++) push_item(noise_item());
      end
    end
  endtask

  initial begin : stimulus
    ftc_in_t odd;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    sender_idle_pct = 10;
    rx_idle_pct     = 56;

    // directed part on the reset settings: target 7.5 C, band 3 C
    push_item(tick_item());
    push_item(sample_item(200, 1'b1, 0));     // above band: cooling starts
    push_item(tick_item());
    push_item(sample_item(140, 1'b1, 0));     // near upper edge: fan
    push_item(sample_item(50, 1'b1, 0));      // below band: run-on
    push_item(sample_item(50, 1'b1, 0));      // run-on restarted
    push_item(tick_item());
    push_item(sample_item(130, 1'b0, 0));     // failed read
    push_item(sample_item(100, 1'b1, 801));   // overheat
    push_item(sample_item(300, 1'b1, 2047));  // overheat while killed
    push_item(cmd_item(CMD_TOGGLE_COMP));
    push_item(cmd_item(CMD_TOGGLE_FAN));
    push_item(cmd_item(CMD_TOGGLE_LIGHT));
    push_item(cmd_item(CMD_KILL_OFF));
    push_item(cmd_item(CMD_KILL_ON));
    push_item(cmd_item(CMD_KILL_OFF));
    for (int c = int'(CMD_KILL_OFF) + 1; c < 8; c++) push_item(cmd_item(3'(c)));
    odd      = noise_item();
    odd.func = FuncUnknown;
    push_item(odd);
    push_item(sample_item(-2048, 1'b1, -2048));
    push_item(sample_item(2047, 1'b1, 800));  // limit itself does not kill
    push_item(cmd_item(CMD_KILL_OFF));
    push_item(sample_item(144, 1'b1, 0));     // exactly on upper edge
    push_item(sample_item(96, 1'b1, 0));      // exactly on lower edge
    push_item(tick_item());
    wait_drained();

    // zero band, margin and timers; kill after one minute on
    set_config(100, 0, 0, 600, 0, 0, 0, 0);
    queue_random(300);
    wait_drained();

    sender_idle_pct = 56;
    rx_idle_pct     = 10;
    set_config(-2048, 1023, 255, 2047, 127, 4095, 255, 255);
    queue_random(300);
    wait_drained();

    sender_idle_pct = 0;
    rx_idle_pct     = 0;
    set_config(80, 40, 8, 500, 1, 7, 3, 5);
    queue_random(240);
    rx_hold_req = 1'b1;
    queue_random(60);
    wait_drained();

    set_config(2047, 17, 3, -2048, 2, 1, 1, 1);
    queue_random(60);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (errors == 0 && relays_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
